### design/arf_pkg.sv
// ----------------------------------------------------------------------------
// arf_pkg
// Shared types, codes and constants for the rate-adaptive audio ring buffer.
// ----------------------------------------------------------------------------
package arf_pkg;

    localparam int FIFO_DEPTH_DEF = 4096;

    localparam int MODE_W     = 2;
    localparam int RATE_W     = 18;
    localparam int ADJ_W      = 10;
    localparam int LEN_W      = 13;
    localparam int ACC_W      = 20;
    localparam int EFF_RATE_W = RATE_W + 1;
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;
    localparam int FILL_W     = 7;
    localparam int DIV_CNT_W  = $clog2(FILL_W);
    localparam int CFG_AW     = 5;
    localparam int CFG_DW     = 32;

    localparam logic [MODE_W-1:0] MODE_PASS    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEAREST = 2'd1;

    localparam logic [RATE_W-1:0] INPUT_RATE_RST  = 18'd48000;
    localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 18'd48000;
    localparam logic [ADJ_W-1:0]  RATE_ADJUST_RST = 10'd144;

    localparam logic [FILL_W-1:0] FILL_LOW  = 7'd40;
    localparam logic [FILL_W-1:0] FILL_HIGH = 7'd60;
    localparam logic [FILL_W-1:0] PERCENT   = 7'd100;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_FILL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        RC_NOMINAL = 2'd0,
        RC_RAISED  = 2'd1,
        RC_LOWERED = 2'd2
    } rate_choice_t;

    typedef enum logic [2:0] {
        REG_MODE          = 3'd0,
        REG_INPUT_RATE    = 3'd1,
        REG_OUTPUT_RATE   = 3'd2,
        REG_RATE_ADJUST   = 3'd3,
        REG_BUFFER_LENGTH = 3'd4
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH,
        S_PUSH_TAKE,
        S_POP,
        S_POP_DATA,
        S_FILL_MUL,
        S_FILL_DIV,
        S_FILL_SET,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic res_clear;
        logic set_full;
        logic store;
        logic acc_add;
        logic acc_settle;
        logic set_taken;
        logic pop_read;
        logic set_pop_data;
        logic set_underrun;
        logic fill_start;
        logic div_step;
        logic fill_set;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       in_valid;
        logic [1:0] op;
        logic       len_zero;
        logic       full;
        logic       empty;
        logic       pass_mode;
        logic       acc_lt_rate;
        logic       div_last;
        logic       out_free;
    } dp_status_t;

endpackage

### design/arf_req_if.sv
// ----------------------------------------------------------------------------
// arf_req_if
// Item channel into the ring buffer: opcode and one stereo frame.
// ----------------------------------------------------------------------------
interface arf_req_if;

    logic                                valid;
    logic                                ready;
    logic [1:0]                          opcode;
    logic signed [arf_pkg::SAMPLE_W-1:0] sample_left;
    logic signed [arf_pkg::SAMPLE_W-1:0] sample_right;

    modport source (output valid, opcode, sample_left, sample_right, input ready);
    modport sink   (input valid, opcode, sample_left, sample_right, output ready);

endinterface

### design/arf_rsp_if.sv
// ----------------------------------------------------------------------------
// arf_rsp_if
// Result channel out of the ring buffer: one result item per request item.
// ----------------------------------------------------------------------------
interface arf_rsp_if;

    logic                                valid;
    logic                                ready;
    logic                                frame_taken;
    logic                                buffer_full;
    logic signed [arf_pkg::SAMPLE_W-1:0] out_left;
    logic signed [arf_pkg::SAMPLE_W-1:0] out_right;
    logic                                underrun;
    logic [arf_pkg::FILL_W-1:0]          fill_percent;

    modport source (
        output valid, frame_taken, buffer_full, out_left, out_right, underrun, fill_percent,
        input  ready
    );
    modport sink (
        input  valid, frame_taken, buffer_full, out_left, out_right, underrun, fill_percent,
        output ready
    );

endinterface

### design/arf_ram.sv
// ----------------------------------------------------------------------------
// arf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/arf_ctrl.sv
// ----------------------------------------------------------------------------
// arf_ctrl
// Sequencer: walks each item through push, pop or fill-level steps.
// ----------------------------------------------------------------------------
module arf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  arf_pkg::dp_status_t st,
    output arf_pkg::dp_cmd_t    cmd
);

    arf_pkg::state_t state_reg;
    arf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arf_pkg::S_IDLE:
            begin
                if (st.in_valid)
                begin
                    state_next = arf_pkg::S_DECODE;
                end
            end
            arf_pkg::S_DECODE:
            begin
                if (st.len_zero)
                begin
                    state_next = arf_pkg::S_REPLY;
                end
                else
                begin
                    case (st.op)
                        arf_pkg::OP_PUSH: state_next = arf_pkg::S_PUSH;
                        arf_pkg::OP_POP:  state_next = arf_pkg::S_POP;
                        arf_pkg::OP_FILL: state_next = arf_pkg::S_FILL_MUL;
                        default:          state_next = arf_pkg::S_REPLY;
                    endcase
                end
            end
            arf_pkg::S_PUSH:
            begin
                if (st.full || st.pass_mode)
                begin
                    state_next = arf_pkg::S_REPLY;
                end
                else
                begin
                    state_next = arf_pkg::S_PUSH_TAKE;
                end
            end
            arf_pkg::S_PUSH_TAKE: state_next = arf_pkg::S_REPLY;
            arf_pkg::S_POP:
            begin
                state_next = st.empty ? arf_pkg::S_REPLY : arf_pkg::S_POP_DATA;
            end
            arf_pkg::S_POP_DATA:  state_next = arf_pkg::S_REPLY;
            arf_pkg::S_FILL_MUL:  state_next = arf_pkg::S_FILL_DIV;
            arf_pkg::S_FILL_DIV:
            begin
                if (st.div_last)
                begin
                    state_next = arf_pkg::S_FILL_SET;
                end
            end
            arf_pkg::S_FILL_SET:  state_next = arf_pkg::S_REPLY;
            arf_pkg::S_REPLY:
            begin
                if (st.out_free)
                begin
                    state_next = arf_pkg::S_IDLE;
                end
            end
            default:              state_next = arf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            arf_pkg::S_IDLE:   cmd.in_ready  = 1'b1;
            arf_pkg::S_DECODE: cmd.res_clear = 1'b1;
            arf_pkg::S_PUSH:
            begin
                if (st.full)
                begin
                    cmd.set_full = 1'b1;
                end
                else if (st.pass_mode)
                begin
                    cmd.store     = 1'b1;
                    cmd.set_taken = 1'b1;
                end
                else if (st.acc_lt_rate)
                begin
                    cmd.store   = 1'b1;
                    cmd.acc_add = 1'b1;
                end
            end
            arf_pkg::S_PUSH_TAKE:
            begin
                cmd.acc_settle = 1'b1;
                cmd.set_taken  = !st.acc_lt_rate;
            end
            arf_pkg::S_POP:
            begin
                cmd.set_underrun = st.empty;
                cmd.pop_read     = !st.empty;
            end
            arf_pkg::S_POP_DATA: cmd.set_pop_data = 1'b1;
            arf_pkg::S_FILL_MUL: cmd.fill_start   = 1'b1;
            arf_pkg::S_FILL_DIV: cmd.div_step     = 1'b1;
            arf_pkg::S_FILL_SET: cmd.fill_set     = 1'b1;
            arf_pkg::S_REPLY:    cmd.out_load     = st.out_free;
            default:             cmd = '0;
        endcase
    end

endmodule

### design/arf_dp.sv
// ----------------------------------------------------------------------------
// arf_dp
// Datapath: registers, ring pointers, phase accumulator, frame RAM,
// fill-level divider and the result register.
// ----------------------------------------------------------------------------
module arf_dp #(
    parameter int FIFO_DEPTH = arf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    arf_req_if.sink                     req,
    arf_rsp_if.source                   rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [arf_pkg::CFG_AW-1:0]  paddr,
    input  logic [arf_pkg::CFG_DW-1:0]  pwdata,
    output logic [arf_pkg::CFG_DW-1:0]  prdata,
    input  arf_pkg::dp_cmd_t            cmd,
    output arf_pkg::dp_status_t         st
);

    localparam int IDX_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int NUM_W  = IDX_W + arf_pkg::FILL_W;
    localparam int ACC_W  = arf_pkg::ACC_W;
    localparam int RATE_W = arf_pkg::EFF_RATE_W;

    // Entries in use: the length register clipped to the RAM depth.
    function automatic logic [CNT_W-1:0] clip_len(input logic [arf_pkg::LEN_W-1:0] l);
        if (32'(l) > 32'(FIFO_DEPTH))
        begin
            return CNT_W'(FIFO_DEPTH);
        end
        return CNT_W'(l);
    endfunction

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] len);
        logic [CNT_W:0] n;
        n = (CNT_W + 1)'(idx) + 1'b1;
        return (n >= (CNT_W + 1)'(len)) ? '0 : IDX_W'(n);
    endfunction

    // Configuration registers
    logic [arf_pkg::MODE_W-1:0] mode_reg;
    logic [arf_pkg::RATE_W-1:0] in_rate_reg;
    logic [arf_pkg::RATE_W-1:0] out_rate_reg;
    logic [arf_pkg::ADJ_W-1:0]  adjust_reg;
    logic [arf_pkg::LEN_W-1:0]  length_reg;

    // Ring state
    logic [IDX_W-1:0]           write_idx_reg;
    logic [IDX_W-1:0]           read_idx_reg;
    logic [IDX_W-1:0]           guard_idx_reg;
    logic [ACC_W:0]             acc_reg;
    arf_pkg::rate_choice_t      rate_choice_reg;

    // Current item
    logic [1:0]                 op_reg;
    logic [arf_pkg::FRAME_W-1:0] frame_reg;

    // Result staging
    logic                       taken_reg;
    logic                       full_reg;
    logic [arf_pkg::SAMPLE_W-1:0] left_reg;
    logic [arf_pkg::SAMPLE_W-1:0] right_reg;
    logic                       under_reg;
    logic [arf_pkg::FILL_W-1:0] fill_reg;

    // Divider
    logic [NUM_W-1:0]           rem_reg;
    logic [NUM_W-1:0]           div_reg;
    logic [arf_pkg::FILL_W-1:0] quo_reg;
    logic [arf_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    // Output register
    logic                       rsp_valid_reg;
    logic                       rsp_taken_reg;
    logic                       rsp_full_reg;
    logic [arf_pkg::SAMPLE_W-1:0] rsp_left_reg;
    logic [arf_pkg::SAMPLE_W-1:0] rsp_right_reg;
    logic                       rsp_under_reg;
    logic [arf_pkg::FILL_W-1:0] rsp_fill_reg;

    logic                       cfg_wr;
    arf_pkg::reg_index_t        cfg_idx;
    logic [CNT_W-1:0]           ring_len;
    logic [CNT_W-1:0]           new_len;
    logic [RATE_W-1:0]          rate;
    logic                       acc_lt_rate;
    logic [ACC_W:0]             acc_settled;
    logic [CNT_W:0]             span;
    logic [IDX_W-1:0]           buffered;
    logic [NUM_W-1:0]           numer;
    logic                       div_ge;
    logic [arf_pkg::FILL_W-1:0] fill_clamped;
    logic [arf_pkg::FRAME_W-1:0] ram_rdata;
    logic                       out_free;

    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = arf_pkg::reg_index_t'(paddr[4:2]);
    assign ring_len = clip_len(length_reg);
    assign new_len  = clip_len(pwdata[arf_pkg::LEN_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= arf_pkg::MODE_NEAREST;
            in_rate_reg  <= arf_pkg::INPUT_RATE_RST;
            out_rate_reg <= arf_pkg::OUTPUT_RATE_RST;
            adjust_reg   <= arf_pkg::RATE_ADJUST_RST;
            length_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                arf_pkg::REG_MODE:          mode_reg     <= pwdata[arf_pkg::MODE_W-1:0];
                arf_pkg::REG_INPUT_RATE:    in_rate_reg  <= pwdata[arf_pkg::RATE_W-1:0];
                arf_pkg::REG_OUTPUT_RATE:   out_rate_reg <= pwdata[arf_pkg::RATE_W-1:0];
                arf_pkg::REG_RATE_ADJUST:   adjust_reg   <= pwdata[arf_pkg::ADJ_W-1:0];
                arf_pkg::REG_BUFFER_LENGTH: length_reg   <= pwdata[arf_pkg::LEN_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            arf_pkg::REG_MODE:          prdata = arf_pkg::CFG_DW'(mode_reg);
            arf_pkg::REG_INPUT_RATE:    prdata = arf_pkg::CFG_DW'(in_rate_reg);
            arf_pkg::REG_OUTPUT_RATE:   prdata = arf_pkg::CFG_DW'(out_rate_reg);
            arf_pkg::REG_RATE_ADJUST:   prdata = arf_pkg::CFG_DW'(adjust_reg);
            arf_pkg::REG_BUFFER_LENGTH: prdata = arf_pkg::CFG_DW'(length_reg);
            default:                    prdata = '0;
        endcase
    end

    // Effective consumer rate
    always_comb
    begin
        case (rate_choice_reg)
            arf_pkg::RC_RAISED:
                rate = RATE_W'(out_rate_reg) + RATE_W'(adjust_reg);
            arf_pkg::RC_LOWERED:
                rate = (out_rate_reg > arf_pkg::RATE_W'(adjust_reg))
                     ? RATE_W'(out_rate_reg - arf_pkg::RATE_W'(adjust_reg)) : '0;
            default:
                rate = RATE_W'(out_rate_reg);
        endcase
    end

    assign acc_lt_rate = acc_reg < (ACC_W + 1)'(rate);
    // Subtract when the frame is taken, then wrap to the accumulator width.
    assign acc_settled = acc_lt_rate ? {1'b0, acc_reg[ACC_W-1:0]}
                       : {1'b0, ACC_W'(acc_reg - (ACC_W + 1)'(rate))};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_idx_reg   <= '0;
            read_idx_reg    <= '0;
            guard_idx_reg   <= '0;
            acc_reg         <= '0;
            rate_choice_reg <= arf_pkg::RC_NOMINAL;
        end
        else
        begin
            if (cfg_wr && cfg_idx == arf_pkg::REG_BUFFER_LENGTH)
            begin
                write_idx_reg <= '0;
                read_idx_reg  <= '0;
                guard_idx_reg <= (new_len != '0) ? IDX_W'(new_len - 1'b1) : '0;
                acc_reg       <= '0;
            end
            else
            begin
                if (cmd.store)
                begin
                    write_idx_reg <= advance(write_idx_reg, ring_len);
                end
                if (cmd.pop_read)
                begin
                    guard_idx_reg <= read_idx_reg;
                    read_idx_reg  <= advance(read_idx_reg, ring_len);
                end
                if (cmd.acc_add)
                begin
                    acc_reg <= acc_reg + (ACC_W + 1)'(in_rate_reg);
                end
                else if (cmd.acc_settle)
                begin
                    acc_reg <= acc_settled;
                end
            end
            // Rate control only reacts when bit 1 of the mode register is set.
            if (cmd.fill_set && mode_reg[1])
            begin
                if (fill_clamped < arf_pkg::FILL_LOW)
                begin
                    rate_choice_reg <= arf_pkg::RC_RAISED;
                end
                else if (fill_clamped > arf_pkg::FILL_HIGH)
                begin
                    rate_choice_reg <= arf_pkg::RC_LOWERED;
                end
                else
                begin
                    rate_choice_reg <= arf_pkg::RC_NOMINAL;
                end
            end
        end
    end

    arf_ram #(
        .WIDTH (arf_pkg::FRAME_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.store),
        .wr_addr (write_idx_reg),
        .wr_data (frame_reg),
        .rd_en   (cmd.pop_read),
        .rd_addr (read_idx_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (req.valid && cmd.in_ready)
        begin
            op_reg    <= req.opcode;
            frame_reg <= {req.sample_right, req.sample_left};
        end
    end

    // Fill level: entries buffered times 100 over the ring length
    always_comb
    begin
        if (write_idx_reg > read_idx_reg)
        begin
            span = (CNT_W + 1)'(write_idx_reg) - (CNT_W + 1)'(read_idx_reg);
        end
        else if (write_idx_reg != read_idx_reg)
        begin
            span = (CNT_W + 1)'(write_idx_reg) + (CNT_W + 1)'(ring_len)
                 - (CNT_W + 1)'(read_idx_reg);
        end
        else
        begin
            span = '0;
        end
    end

    assign buffered     = IDX_W'(span);
    assign numer        = NUM_W'(buffered) * NUM_W'(arf_pkg::PERCENT);
    assign div_ge       = rem_reg >= div_reg;
    assign fill_clamped = (quo_reg > arf_pkg::PERCENT) ? arf_pkg::PERCENT : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_start)
        begin
            rem_reg     <= numer;
            div_reg     <= NUM_W'(ring_len) << (arf_pkg::FILL_W - 1);
            quo_reg     <= '0;
            div_cnt_reg <= arf_pkg::DIV_CNT_W'(arf_pkg::FILL_W - 1);
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - div_reg;
            end
            quo_reg     <= {quo_reg[arf_pkg::FILL_W-2:0], div_ge};
            div_reg     <= div_reg >> 1;
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_clear)
        begin
            taken_reg <= 1'b0;
            full_reg  <= 1'b0;
            left_reg  <= '0;
            right_reg <= '0;
            under_reg <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            if (cmd.set_taken)
            begin
                taken_reg <= 1'b1;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
            if (cmd.set_underrun)
            begin
                under_reg <= 1'b1;
            end
            if (cmd.set_pop_data)
            begin
                left_reg  <= ram_rdata[arf_pkg::SAMPLE_W-1:0];
                right_reg <= ram_rdata[arf_pkg::FRAME_W-1:arf_pkg::SAMPLE_W];
            end
            if (cmd.fill_set)
            begin
                fill_reg <= fill_clamped;
            end
        end
    end

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_taken_reg <= taken_reg;
            rsp_full_reg  <= full_reg;
            rsp_left_reg  <= left_reg;
            rsp_right_reg <= right_reg;
            rsp_under_reg <= under_reg;
            rsp_fill_reg  <= fill_reg;
        end
    end

    assign req.ready        = cmd.in_ready;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.frame_taken  = rsp_taken_reg;
    assign rsp.buffer_full  = rsp_full_reg;
    assign rsp.out_left     = rsp_left_reg;
    assign rsp.out_right    = rsp_right_reg;
    assign rsp.underrun     = rsp_under_reg;
    assign rsp.fill_percent = rsp_fill_reg;

    assign st.in_valid    = req.valid;
    assign st.op          = op_reg;
    assign st.len_zero    = ring_len == '0;
    assign st.full        = write_idx_reg == guard_idx_reg;
    assign st.empty       = read_idx_reg == write_idx_reg;
    assign st.pass_mode   = mode_reg == arf_pkg::MODE_PASS;
    assign st.acc_lt_rate = acc_lt_rate;
    assign st.div_last    = div_cnt_reg == '0;
    assign st.out_free    = out_free;

endmodule

### design/audio_rate_adaptive_fifo.sv
// ----------------------------------------------------------------------------
// audio_rate_adaptive_fifo
// Stereo audio ring buffer with nearest-neighbour rate conversion and
// dynamic rate control, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Items are handled one at a time; the next item is accepted as soon as the
// previous result sits in the output register, even if it is not yet taken.
// An item on a zero-length ring or with an unknown opcode goes straight to
// the reply; pushes, pops and rate updates first pass through their own
// work states. A pop that returns data waits for the registered frame RAM
// read, and a rate update waits for the 7-step restoring divider that
// forms the fill percentage. Registers sit at byte
// address 4*index: mode, input_rate, output_rate, rate_adjust,
// buffer_length. Writing buffer_length resets the pointers and the phase
// accumulator; write registers only while no item is in flight. The frame
// RAM is not cleared, and no pop can reach an entry that was not written.
module audio_rate_adaptive_fifo #(
    parameter int FIFO_DEPTH = arf_pkg::FIFO_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    arf_req_if.sink                    req,
    arf_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arf_pkg::CFG_AW-1:0] paddr,
    input  logic [arf_pkg::CFG_DW-1:0] pwdata,
    output logic [arf_pkg::CFG_DW-1:0] prdata,
    output logic                       pready
);

    arf_pkg::dp_cmd_t    cmd;
    arf_pkg::dp_status_t st;

    assign pready = 1'b1;

    arf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    arf_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cmd     (cmd),
        .st      (st)
    );

endmodule

### design/arf_checker.sv
// ----------------------------------------------------------------------------
// arf_checker
// Port-level checks on the ring buffer's item and result channels.
// ----------------------------------------------------------------------------
module arf_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic                               frame_taken,
    input logic                               buffer_full,
    input logic [arf_pkg::SAMPLE_W-1:0]       out_left,
    input logic [arf_pkg::SAMPLE_W-1:0]       out_right,
    input logic                               underrun,
    input logic [arf_pkg::FILL_W-1:0]         fill_percent
);

    logic [1:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = req_valid && req_ready;
    assign out_acc = rsp_valid && rsp_ready;

    // Count items accepted but not yet answered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pending_reg != 2'd0)
        else $error("result delivered with no item outstanding");

    a_one_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !req_ready)
        else $error("item accepted while one in work and one result waiting");

    a_underrun_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && underrun |-> out_left == '0 && out_right == '0
                                  && !frame_taken && !buffer_full && fill_percent == '0)
        else $error("underrun result carries other fields");

    a_fields_sane: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(frame_taken && buffer_full) && fill_percent <= arf_pkg::PERCENT)
        else $error("inconsistent result fields");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_left) && $stable(out_right)
                                    && $stable(fill_percent) && $stable(underrun))
        else $error("stalled result changed");

endmodule

bind audio_rate_adaptive_fifo arf_checker u_arf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .frame_taken  (rsp.frame_taken),
    .buffer_full  (rsp.buffer_full),
    .out_left     (rsp.out_left),
    .out_right    (rsp.out_right),
    .underrun     (rsp.underrun),
    .fill_percent (rsp.fill_percent)
);
